// File: hdl/bmpp_pkg.sv
// Shared types and constants for the binomial mod prime power block.
package bmpp_pkg;

   // Register indexes on the configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRIME    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPONENT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS  = 2'd2;

   localparam int EXP_WIDTH = 5;

   // Class of an item as decided by the front end
   typedef enum logic [1:0] {
      KIND_ZERO,
      KIND_ONE,
      KIND_NMOD,
      KIND_GRAN
   } kind_type;

   // Queue head status handed from front to back
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } head_type;

endpackage

// File: hdl/bmpp_req_if.sv
// Request and response channel interfaces.
interface bmpp_req_if #(parameter int AW = 32) ();
   logic          valid;
   logic          ready;
   logic [AW-1:0] top;
   logic [AW-1:0] choose;
   modport source (output valid, top, choose, input ready);
   modport sink   (input valid, top, choose, output ready);
endinterface

interface bmpp_rsp_if #(parameter int MW = 16) ();
   logic          valid;
   logic          ready;
   logic [MW-1:0] residue;
   modport source (output valid, residue, input ready);
   modport sink   (input valid, residue, output ready);
endinterface

// File: hdl/bmpp_div.sv
// Restoring divider, one quotient bit per cycle.
module bmpp_div #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic          done,
   output logic [DW-1:0] quot,
   output logic [DW-1:0] rem
);
   localparam int CW = $clog2(DW);

   logic [DW-1:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   shifted, diff;

   // Load operands on start, else trial subtract of the next partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[DW-1]};
      diff    = shifted - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DW]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;
endmodule

// File: hdl/bmpp_front.sv
// Front end: accept requests, classify them and queue them for the back end.
module bmpp_front #(
   parameter int AW = 32,
   parameter int MW = 16
) (
   input  logic               clock,
   input  logic               reset,
   bmpp_req_if.sink           req,
   input  logic [MW-1:0]      prime,
   input  logic [MW-1:0]      modulus,
   output bmpp_pkg::head_type head,
   output logic [AW-1:0]      head_top,
   output logic [AW-1:0]      head_choose,
   input  logic               pop
);
   localparam int DEPTH = 2;

   logic [AW-1:0]      top_ff [DEPTH];
   logic [AW-1:0]      cho_ff [DEPTH];
   bmpp_pkg::kind_type kind_ff [DEPTH];
   logic               wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               push;
   bmpp_pkg::kind_type kind;

   // Classify the special cases
   always_comb begin
      if (modulus < MW'(2))
         kind = bmpp_pkg::KIND_ZERO;
      else if (req.choose > req.top)
         kind = bmpp_pkg::KIND_ZERO;
      else if (req.choose == '0 || req.choose == req.top)
         kind = bmpp_pkg::KIND_ONE;
      else if (req.choose == AW'(1) || req.choose == req.top - AW'(1))
         kind = bmpp_pkg::KIND_NMOD;
      else if (prime < MW'(2))
         kind = bmpp_pkg::KIND_ZERO;
      else
         kind = bmpp_pkg::KIND_GRAN;
   end

   assign req.ready = (cnt_ff != 2'(DEPTH));
   assign push      = req.valid && req.ready;

   // Advance queue pointers
   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         top_ff[wr_ff]  <= req.top;
         cho_ff[wr_ff]  <= req.choose;
         kind_ff[wr_ff] <= kind;
      end
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   assign head.valid  = (cnt_ff != '0);
   assign head.kind   = kind_ff[rd_ff];
   assign head_top    = top_ff[rd_ff];
   assign head_choose = cho_ff[rd_ff];
endmodule

// File: hdl/bmpp_back.sv
// Back end: sequencer for the Granville evaluation over one shared divider.
module bmpp_back #(
   parameter int AW = 32,
   parameter int MW = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bmpp_pkg::head_type                head,
   input  logic [AW-1:0]                     head_top,
   input  logic [AW-1:0]                     head_choose,
   output logic                              pop,
   input  logic [MW-1:0]                     prime,
   input  logic [bmpp_pkg::EXP_WIDTH-1:0]    exponent,
   input  logic [MW-1:0]                     modulus,
   bmpp_rsp_if.source                        rsp
);
   localparam int DW = (AW > 2 * MW) ? AW : 2 * MW;
   localparam int TW = MW + 2;
   localparam int EW = $clog2(AW + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_NMOD, S_DIGIT, S_XMOD, S_FACT, S_QUOT, S_CARRY, S_PMOD,
      S_LEAD, S_SIGN, S_EUC, S_EUCD, S_EUCM, S_EUCU, S_EUCEND,
      S_MMMUL, S_MMDIV, S_DWAIT, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      R_FACT, R_FOLD, R_LEAD, R_FIN1, R_FIN2
   } ret_type;

   state_type            state_ff, from_ff;
   ret_type              ret_ff;
   logic [AW-1:0]        n_ff, k_ff, d_ff, nq_ff, kq_ff, dq_ff;
   logic [1:0]           sel_ff;
   logic [EW-1:0]        e0_ff, eq_ff, j_ff, cnt_ff;
   logic [MW-1:0]        num_ff, den_ff, acc_ff, x_ff, i_ff, cp_ff;
   logic [MW-1:0]        pmod_ff, lead_ff, inv_ff, mma_ff, mmb_ff, res_ff;
   logic [2*MW-1:0]      prod_ff;
   logic signed [TW-1:0] eu_t_ff, eu_nt_ff, eu_p_ff;
   logic [MW-1:0]        eu_r_ff, eu_nr_ff, eu_q_ff;
   logic                 rsp_valid_ff;
   logic [MW-1:0]        rsp_res_ff;

   logic                 div_go, div_busy, div_done;
   logic [DW-1:0]        div_a, div_b, div_quot, div_rem;
   logic [AW-1:0]        src;
   logic [AW:0]          ksum;
   logic [EW-1:0]        j_next;
   logic [MW-1:0]        cp_next, rem_m;
   logic signed [TW-1:0] inv_s;
   logic                 neg;

   bmpp_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_a),
      .divisor  (div_b),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // Select the divider operands for each launching state
   always_comb begin
      case (sel_ff)
         2'd0:    src = n_ff;
         2'd1:    src = k_ff;
         default: src = d_ff;
      endcase
      div_go = 1'b1;
      div_a  = DW'(n_ff);
      div_b  = DW'(modulus);
      case (state_ff)
         S_NMOD:  div_a = DW'(n_ff);
         S_XMOD:  div_a = DW'(src);
         S_QUOT: begin
            div_a = DW'(src);
            div_b = DW'(prime);
         end
         S_PMOD:  div_a = DW'(prime);
         S_MMDIV: div_a = DW'(prod_ff);
         S_EUCD: begin
            div_a = DW'(eu_r_ff);
            div_b = DW'(eu_nr_ff);
         end
         default: div_go = 1'b0;
      endcase
   end

   assign pop     = (state_ff == S_IDLE) && head.valid;
   assign ksum    = {1'b0, kq_ff} + {1'b0, dq_ff};
   assign j_next  = j_ff + 1'b1;
   assign cp_next = (cp_ff + 1'b1 == prime) ? '0 : cp_ff + 1'b1;
   assign rem_m   = MW'(div_rem);
   assign neg     = eq_ff[0] && !(prime == MW'(2) && exponent >= 5'd3);
   assign inv_s   = eu_t_ff + $signed(TW'(modulus));

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop a taken beat unless the next result loads this cycle
         if (rsp_valid_ff && rsp.ready && state_ff != S_DONE)
            rsp_valid_ff <= 1'b0;
         if (div_go) begin
            from_ff  <= state_ff;
            state_ff <= S_DWAIT;
         end
         case (state_ff)
            S_IDLE: begin
               if (head.valid) begin
                  n_ff   <= head_top;
                  k_ff   <= head_choose;
                  d_ff   <= head_top - head_choose;
                  num_ff <= MW'(1);
                  den_ff <= MW'(1);
                  e0_ff  <= '0;
                  eq_ff  <= '0;
                  j_ff   <= '0;
                  case (head.kind)
                     bmpp_pkg::KIND_ZERO: begin
                        res_ff   <= '0;
                        state_ff <= S_DONE;
                     end
                     bmpp_pkg::KIND_ONE: begin
                        res_ff   <= MW'(1);
                        state_ff <= S_DONE;
                     end
                     bmpp_pkg::KIND_NMOD: state_ff <= S_NMOD;
                     default:             state_ff <= S_DIGIT;
                  endcase
               end
            end
            S_DIGIT: begin
               sel_ff   <= 2'd0;
               state_ff <= (n_ff == '0) ? S_PMOD : S_XMOD;
            end
            S_FACT: begin
               if (i_ff > x_ff) begin
                  mma_ff   <= (sel_ff == 2'd0) ? num_ff : den_ff;
                  mmb_ff   <= acc_ff;
                  ret_ff   <= R_FOLD;
                  state_ff <= S_MMMUL;
               end else if (cp_ff != '0) begin
                  mma_ff   <= acc_ff;
                  mmb_ff   <= i_ff;
                  ret_ff   <= R_FACT;
                  state_ff <= S_MMMUL;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  cp_ff <= cp_next;
               end
            end
            S_CARRY: begin
               j_ff <= j_next;
               if ({1'b0, nq_ff} != ksum) begin
                  e0_ff <= e0_ff + 1'b1;
                  if (32'(j_next) >= 32'(exponent))
                     eq_ff <= eq_ff + 1'b1;
               end
               n_ff     <= nq_ff;
               k_ff     <= kq_ff;
               d_ff     <= dq_ff;
               state_ff <= S_DIGIT;
            end
            S_LEAD: begin
               if (cnt_ff < e0_ff) begin
                  mma_ff   <= lead_ff;
                  mmb_ff   <= pmod_ff;
                  ret_ff   <= R_LEAD;
                  state_ff <= S_MMMUL;
               end else begin
                  state_ff <= S_SIGN;
               end
            end
            S_SIGN: begin
               if (lead_ff == '0) begin
                  res_ff   <= '0;
                  state_ff <= S_DONE;
               end else begin
                  if (neg)
                     lead_ff <= modulus - lead_ff;
                  eu_t_ff  <= '0;
                  eu_nt_ff <= TW'(1);
                  eu_r_ff  <= modulus;
                  eu_nr_ff <= den_ff;
                  state_ff <= S_EUC;
               end
            end
            S_EUC:  state_ff <= (eu_nr_ff == '0) ? S_EUCEND : S_EUCD;
            S_EUCM: begin
               eu_p_ff  <= $signed({2'b00, eu_q_ff}) * eu_nt_ff;
               state_ff <= S_EUCU;
            end
            S_EUCU: begin
               eu_t_ff  <= eu_nt_ff;
               eu_nt_ff <= eu_t_ff - eu_p_ff;
               eu_r_ff  <= eu_nr_ff;
               eu_nr_ff <= rem_m;
               state_ff <= S_EUC;
            end
            S_EUCEND: begin
               if (eu_r_ff != MW'(1))
                  inv_ff <= '0;
               else if (eu_t_ff < 0)
                  inv_ff <= MW'(inv_s);
               else
                  inv_ff <= MW'(eu_t_ff);
               mma_ff   <= lead_ff;
               mmb_ff   <= num_ff;
               ret_ff   <= R_FIN1;
               state_ff <= S_MMMUL;
            end
            S_MMMUL: begin
               prod_ff  <= mma_ff * mmb_ff;
               state_ff <= S_MMDIV;
            end
            S_DWAIT: begin
               if (div_done) begin
                  case (from_ff)
                     S_NMOD: begin
                        res_ff   <= rem_m;
                        state_ff <= S_DONE;
                     end
                     S_XMOD: begin
                        x_ff     <= rem_m;
                        i_ff     <= MW'(1);
                        cp_ff    <= MW'(1);
                        acc_ff   <= MW'(1);
                        state_ff <= S_FACT;
                     end
                     S_QUOT: begin
                        case (sel_ff)
                           2'd0:    nq_ff <= AW'(div_quot);
                           2'd1:    kq_ff <= AW'(div_quot);
                           default: dq_ff <= AW'(div_quot);
                        endcase
                        if (sel_ff == 2'd2) begin
                           sel_ff   <= 2'd0;
                           state_ff <= S_CARRY;
                        end else begin
                           sel_ff   <= sel_ff + 1'b1;
                           state_ff <= S_QUOT;
                        end
                     end
                     S_PMOD: begin
                        pmod_ff  <= rem_m;
                        lead_ff  <= MW'(1);
                        cnt_ff   <= '0;
                        state_ff <= S_LEAD;
                     end
                     S_EUCD: begin
                        eu_q_ff  <= MW'(div_quot);
                        state_ff <= S_EUCM;
                     end
                     default: begin
                        case (ret_ff)
                           R_FACT: begin
                              acc_ff   <= rem_m;
                              i_ff     <= i_ff + 1'b1;
                              cp_ff    <= cp_next;
                              state_ff <= S_FACT;
                           end
                           R_FOLD: begin
                              if (sel_ff == 2'd0)
                                 num_ff <= rem_m;
                              else
                                 den_ff <= rem_m;
                              if (sel_ff == 2'd2) begin
                                 sel_ff   <= 2'd0;
                                 state_ff <= S_QUOT;
                              end else begin
                                 sel_ff   <= sel_ff + 1'b1;
                                 state_ff <= S_XMOD;
                              end
                           end
                           R_LEAD: begin
                              lead_ff  <= rem_m;
                              cnt_ff   <= cnt_ff + 1'b1;
                              state_ff <= S_LEAD;
                           end
                           R_FIN1: begin
                              mma_ff   <= rem_m;
                              mmb_ff   <= inv_ff;
                              ret_ff   <= R_FIN2;
                              state_ff <= S_MMMUL;
                           end
                           default: begin
                              res_ff   <= rem_m;
                              state_ff <= S_DONE;
                           end
                        endcase
                     end
                  endcase
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_res_ff   <= res_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.residue = rsp_res_ff;

`ifndef NO_ASSERTIONS
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_go |-> !div_busy)
      else $error("divider launched while busy");
   a_eq_le_e0: assert property (@(posedge clock) disable iff (reset)
      eq_ff <= e0_ff || state_ff == S_IDLE)
      else $error("high carry count exceeds total carry count");
   a_wait_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DWAIT && !div_busy && !div_done) |-> $past(div_go))
      else $error("waiting on an idle divider");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff != S_IDLE)
      else $error("popped item not taken up");
`endif
endmodule

// File: hdl/binomial_mod_prime_power.sv
// Top level of the binomial coefficient modulo a prime power block.
//
// Usage:
//   req carries one item (top = n, choose = k) per beat; rsp returns one beat
//   with residue = binom(n,k) mod modulus for each request, in order.
//   Configuration: csr_write with csr_index 0 (prime), 1 (exponent) or
//   2 (modulus) and csr_data; modulus must equal prime**exponent. Write only
//   while no request is in flight.
//   Trivial cases (k > n, k = 0, k = n) go from the queue to the result
//   register without the divider; k = 1 or k = n-1 take one divide of n by
//   modulus. The divider is DW = max(ARG_WIDTH, 2*MOD_WIDTH) bits wide.
//   The general case walks every base-p digit of n; per digit it builds three
//   p-free factorials with one modular multiply per factor, and each modular
//   multiply runs on the single shared divider.
//   A two-beat queue takes new requests while an item is worked on, and a
//   result register holds the response when rsp is stalled; the sequencer
//   waits on a stalled result before starting the next item.
//   Reset (synchronous, active high) empties the queue, drops any pending
//   response and restores prime = 2, exponent = 1, modulus = 2.
module binomial_mod_prime_power #(
   parameter int ARG_WIDTH = 32,
   parameter int MOD_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   bmpp_req_if.sink                             req,
   bmpp_rsp_if.source                           rsp,
   input  logic                                 csr_write,
   input  logic [bmpp_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [((MOD_WIDTH > 5) ? MOD_WIDTH : 5)-1:0] csr_data
);
   logic [MOD_WIDTH-1:0]           prime_ff, modulus_ff;
   logic [bmpp_pkg::EXP_WIDTH-1:0] exponent_ff;
   bmpp_pkg::head_type             head;
   logic [ARG_WIDTH-1:0]           head_top, head_choose;
   logic                           pop;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prime_ff    <= MOD_WIDTH'(2);
         exponent_ff <= 5'd1;
         modulus_ff  <= MOD_WIDTH'(2);
      end else if (csr_write) begin
         case (csr_index)
            bmpp_pkg::CSR_PRIME:    prime_ff    <= csr_data[MOD_WIDTH-1:0];
            bmpp_pkg::CSR_EXPONENT: exponent_ff <= csr_data[4:0];
            bmpp_pkg::CSR_MODULUS:  modulus_ff  <= csr_data[MOD_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   bmpp_front #(.AW(ARG_WIDTH), .MW(MOD_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .prime       (prime_ff),
      .modulus     (modulus_ff),
      .head        (head),
      .head_top    (head_top),
      .head_choose (head_choose),
      .pop         (pop)
   );

   bmpp_back #(.AW(ARG_WIDTH), .MW(MOD_WIDTH)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_top    (head_top),
      .head_choose (head_choose),
      .pop         (pop),
      .prime       (prime_ff),
      .exponent    (exponent_ff),
      .modulus     (modulus_ff),
      .rsp         (rsp)
   );
endmodule
